// ===== hdl/acdr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// acdr_pkg
// Shared sizes, register indexes, state codes and the divider request for
// the click detect and repair block.
// ---------------------------------------------------------------------------
package acdr_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int HP_BITS       = SAMPLE_BITS + 2;
    localparam int MAX_WINDOW    = 256;
    localparam int MAX_LOOKAHEAD = 1024;
    localparam int QCAP = ((MAX_LOOKAHEAD > 2 * MAX_WINDOW + 2) ?
                           MAX_LOOKAHEAD : (2 * MAX_WINDOW + 2)) + 1;
    localparam int Q_AW      = $clog2(QCAP);
    localparam int P_AW      = $clog2(MAX_WINDOW);
    localparam int W_BITS    = 9;
    localparam int FILL_BITS = 11;
    localparam int CNT_BITS  = 10;
    localparam int SUM_BITS  = 33;
    localparam int DIV_NB    = 38;
    localparam int DEN_BITS  = 10;
    localparam int CFG_BITS  = 23;

    localparam logic [2:0] REG_HP_ALPHA  = 3'd0;
    localparam logic [2:0] REG_PAPR_TH   = 3'd1;
    localparam logic [2:0] REG_HP_TH     = 3'd2;
    localparam logic [2:0] REG_SLEW      = 3'd3;
    localparam logic [2:0] REG_WINDOW    = 3'd4;
    localparam logic [2:0] REG_DELAY     = 3'd5;

    // eps of the slew floor times 256
    localparam logic [14:0] EPS_SLEW_256 = 15'd21504;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_HPD   = 14'b00000000000010,
        ST_HPC   = 14'b00000000000100,
        ST_PUSH  = 14'b00000000001000,
        ST_SCAN  = 14'b00000000010000,
        ST_DRAIN = 14'b00000000100000,
        ST_EVAL0 = 14'b00000001000000,
        ST_EVAL1 = 14'b00000010000000,
        ST_EVAL2 = 14'b00000100000000,
        ST_MUL   = 14'b00001000000000,
        ST_DIVS  = 14'b00010000000000,
        ST_DIVW  = 14'b00100000000000,
        ST_REM   = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_NB-1:0]   dividend;
        logic [DEN_BITS-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

// ===== hdl/acdr_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// acdr_ram
// Simple dual-port synchronous RAM, one write and one registered read.
// ---------------------------------------------------------------------------
module acdr_ram #(
    parameter int AW = 8,
    parameter int DW = 24
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/acdr_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// acdr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module acdr_div
    import acdr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire div_req_t          req,
    output logic                   done,
    output logic [DIV_NB-1:0]      quot
);

    localparam int CW = $clog2(DIV_NB + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DIV_NB-1:0]   q_reg, q_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        trial     = {rem_reg, q_reg[DIV_NB-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = req.divisor;
            q_next    = req.dividend;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_BITS-1:0];
                q_next   = {q_reg[DIV_NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_BITS-1:0];
                q_next   = {q_reg[DIV_NB-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ===== hdl/audio_click_detect_repair.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// audio_click_detect_repair
// One-pole high-pass sidechain, lookahead queue and past ring in RAM,
// click detection against the surrounding mean level, linear ramp repair.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_ready  | sample_in
//  out      | out_valid / out_ready| sample_out, removed_out, click_started
//  cfg      | cfg_we               | cfg_index, cfg_data
//
//  a beat that only fills the queue runs the high-pass steps, the push
//  and the output step; a judged beat adds W+2 queue reads over one RAM
//  read port, and a repair adds the ramp product and its 38-bit quotient
//  no clearing pass after reset; in_ready is high only between beats
//  a finished result waits in the output register while the next beat
//  is accepted; a stalled output holds the following result back
// ---------------------------------------------------------------------------
module audio_click_detect_repair
    import acdr_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic signed [SAMPLE_BITS-1:0]      removed_out,
    output logic                               click_started,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [CFG_BITS-1:0]           cfg_data
);

    localparam int QDW = SAMPLE_BITS + HP_BITS;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = (40'sd1 <<< (SAMPLE_BITS - 1)) - 40'sd1;
        lo = -hi - 40'sd1;
        if (v > hi)
            sat_s = hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            sat_s = lo[SAMPLE_BITS-1:0];
        else
            sat_s = v[SAMPLE_BITS-1:0];
    endfunction

    // configuration
    logic [15:0]         alpha_reg;
    logic [11:0]         papr_reg;
    logic [22:0]         hpth_reg;
    logic [9:0]          slew_reg;
    logic [8:0]          win_reg;
    logic [10:0]         dly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 16'd32014;
            papr_reg  <= 12'd614;
            hpth_reg  <= 23'd57880;
            slew_reg  <= 10'd343;
            win_reg   <= 9'd96;
            dly_reg   <= 11'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HP_ALPHA: alpha_reg <= cfg_data[15:0];
                REG_PAPR_TH:  papr_reg  <= cfg_data[11:0];
                REG_HP_TH:    hpth_reg  <= cfg_data[22:0];
                REG_SLEW:     slew_reg  <= cfg_data[9:0];
                REG_WINDOW:   win_reg   <= cfg_data[8:0];
                REG_DELAY:    dly_reg   <= cfg_data[10:0];
                default:      ;
            endcase
        end
    end

    logic [W_BITS-1:0]    w;
    logic [FILL_BITS-1:0] dl;
    logic [FILL_BITS-1:0] two_w2;
    logic [FILL_BITS-1:0] need;

    always_comb
    begin
        if (win_reg < 9'd4)
            w = 9'd4;
        else if (win_reg > 9'(MAX_WINDOW))
            w = 9'(MAX_WINDOW);
        else
            w = win_reg;
        if (dly_reg < 11'd6)
            dl = 11'd6;
        else if (dly_reg > 11'(MAX_LOOKAHEAD))
            dl = 11'(MAX_LOOKAHEAD);
        else
            dl = dly_reg;
        two_w2 = {1'b0, w, 1'b0} + 11'd2;
        need   = (dl > two_w2) ? dl : two_w2;
    end

    // state
    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;
    logic signed [26:0]            d_reg, d_next;
    logic signed [SAMPLE_BITS-1:0] hli_reg, hli_next;
    logic signed [HP_BITS-1:0]     hlo_reg, hlo_next;
    logic signed [HP_BITS-1:0]     lhd_reg, lhd_next;
    logic [FILL_BITS-1:0]          fill_reg, fill_next;
    logic [Q_AW-1:0]               head_reg, head_next;
    logic [P_AW-1:0]               wr_reg, wr_next;
    logic [W_BITS-1:0]             pfill_reg, pfill_next;
    logic                          rep_reg, rep_next;
    logic [W_BITS-1:0]             step_reg, step_next;
    logic signed [SAMPLE_BITS-1:0] al_reg, al_next;
    logic signed [SAMPLE_BITS-1:0] ar_reg, ar_next;

    logic [W_BITS-1:0]             i_reg, i_next;
    logic                          rv_reg, rv_next;
    logic [W_BITS-1:0]             tag_reg, tag_next;
    logic [SUM_BITS-1:0]           sum_reg, sum_next;
    logic signed [SAMPLE_BITS-1:0] curr_reg, curr_next;
    logic signed [HP_BITS-1:0]     hp0_reg, hp0_next;
    logic signed [SAMPLE_BITS-1:0] alc_reg, alc_next;
    logic signed [SAMPLE_BITS-1:0] arc_reg, arc_next;
    logic [CNT_BITS-1:0]           cnt_reg, cnt_next;
    logic [SUM_BITS-1:0]           avgf_reg, avgf_next;
    logic [26:0]                   hdm_reg, hdm_next;
    logic [SAMPLE_BITS-1:0]        cm_reg, cm_next;
    logic                          hok_reg, hok_next;
    logic [33:0]                   pa_reg, pa_next;
    logic [44:0]                   pb_reg, pb_next;
    logic [36:0]                   sa_reg, sa_next;
    logic [42:0]                   sb_reg, sb_next;
    logic [24:0]                   se_reg, se_next;
    logic signed [35:0]            prod_reg, prod_next;
    logic                          neg_reg, neg_next;
    logic signed [SAMPLE_BITS-1:0] y_reg, y_next;
    logic signed [SAMPLE_BITS-1:0] rm_reg, rm_next;
    logic                          st_reg, st_next;
    logic                          judged_reg, judged_next;

    logic                          ov_reg, ov_next;
    logic signed [SAMPLE_BITS-1:0] oy_reg, oy_next;
    logic signed [SAMPLE_BITS-1:0] orm_reg, orm_next;
    logic                          ost_reg, ost_next;

    // memories
    logic                 qa_we;
    logic [Q_AW-1:0]      qa_waddr;
    logic [Q_AW-1:0]      qa_raddr;
    logic [QDW-1:0]       qa_rdata;
    logic                 pr_we;
    logic [P_AW-1:0]      pr_raddr;
    logic [SAMPLE_BITS-1:0] pr_rdata;

    acdr_ram #(.AW(Q_AW), .DW(QDW)) u_ahead (
        .clk   (clk),
        .we    (qa_we),
        .waddr (qa_waddr),
        .wdata ({x_reg, hlo_reg}),
        .raddr (qa_raddr),
        .rdata (qa_rdata)
    );

    acdr_ram #(.AW(P_AW), .DW(SAMPLE_BITS)) u_past (
        .clk   (clk),
        .we    (pr_we),
        .waddr (wr_reg),
        .wdata (curr_reg),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    div_req_t          dreq;
    logic              d_done;
    logic [DIV_NB-1:0] d_quot;

    acdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (d_done),
        .quot  (d_quot)
    );

    // datapath helpers
    logic signed [43:0]            hp_prod;
    logic signed [43:0]            hp_sh;
    logic signed [HP_BITS-1:0]     hp_sat;
    logic [FILL_BITS-1:0]          fill_push;
    logic signed [SAMPLE_BITS-1:0] araw;
    logic signed [HP_BITS-1:0]     ahp;
    logic signed [SAMPLE_BITS-1:0] praw;
    logic [SAMPLE_BITS-1:0]        amag;
    logic [SAMPLE_BITS-1:0]        pmag;
    logic [W_BITS-1:0]             pcnt;
    logic [CNT_BITS-1:0]           cnt_c;
    logic signed [26:0]            hd;
    logic [HP_BITS-1:0]            hp0m;
    logic [42:0]                   slim;
    logic                          p_ok;
    logic                          s_ok;
    logic                          start;
    logic signed [24:0]            adiff;
    logic [CNT_BITS-1:0]           k;
    logic signed [DIV_NB-1:0]      numer;
    logic [DEN_BITS-1:0]           den;
    logic signed [DIV_NB:0]        off;
    logic [W_BITS-1:0]             step_inc;

    always_comb
    begin
        hp_prod = $signed({1'b0, alpha_reg}) * d_reg;
        hp_sh   = (hp_prod + 44'sd32768) >>> 16;
        if (hp_sh > ((44'sd1 <<< (HP_BITS - 1)) - 44'sd1))
            hp_sat = {1'b0, {(HP_BITS - 1){1'b1}}};
        else if (hp_sh < -(44'sd1 <<< (HP_BITS - 1)))
            hp_sat = {1'b1, {(HP_BITS - 1){1'b0}}};
        else
            hp_sat = hp_sh[HP_BITS-1:0];

        fill_push = (fill_reg < FILL_BITS'(QCAP)) ? fill_reg + 1'b1 : fill_reg;

        araw = qa_rdata[QDW-1:HP_BITS];
        ahp  = qa_rdata[HP_BITS-1:0];
        praw = pr_rdata;
        amag = araw[SAMPLE_BITS-1] ? (~araw + 1'b1) : araw;
        pmag = praw[SAMPLE_BITS-1] ? (~praw + 1'b1) : praw;
        pcnt = (pfill_reg < w) ? pfill_reg : w;
        cnt_c   = CNT_BITS'(w) + CNT_BITS'(pcnt);
        hd   = 27'(hp0_reg) - 27'(lhd_reg);
        hp0m = hp0_reg[HP_BITS-1] ? (~hp0_reg + 1'b1) : hp0_reg;
        slim = (sb_reg > 43'(se_reg)) ? sb_reg : 43'(se_reg);
        p_ok = {3'b000, pa_reg, 8'b0} > pb_reg;
        s_ok = {sa_reg, 8'b0} > 45'(slim);
        start = p_ok && hok_reg && s_ok && !rep_reg;
        adiff = 25'(ar_reg) - 25'(al_reg);
        k     = CNT_BITS'(step_reg) + 1'b1;
        den   = {w, 1'b0} + 10'd2;
        numer = DIV_NB'($signed({prod_reg, 1'b0})) + DIV_NB'(w) + DIV_NB'(1);
        off   = neg_reg ? -$signed({1'b0, d_quot}) : $signed({1'b0, d_quot});
        step_inc = step_reg + 1'b1;
    end

    always_comb
    begin
        state_next  = state_reg;
        x_next      = x_reg;
        d_next      = d_reg;
        hli_next    = hli_reg;
        hlo_next    = hlo_reg;
        lhd_next    = lhd_reg;
        fill_next   = fill_reg;
        head_next   = head_reg;
        wr_next     = wr_reg;
        pfill_next  = pfill_reg;
        rep_next    = rep_reg;
        step_next   = step_reg;
        al_next     = al_reg;
        ar_next     = ar_reg;
        i_next      = i_reg;
        rv_next     = 1'b0;
        tag_next    = tag_reg;
        sum_next    = sum_reg;
        curr_next   = curr_reg;
        hp0_next    = hp0_reg;
        alc_next    = alc_reg;
        arc_next    = arc_reg;
        cnt_next    = cnt_reg;
        avgf_next   = avgf_reg;
        hdm_next    = hdm_reg;
        cm_next     = cm_reg;
        hok_next    = hok_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        sa_next     = sa_reg;
        sb_next     = sb_reg;
        se_next     = se_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        y_next      = y_reg;
        rm_next     = rm_reg;
        st_next     = st_reg;
        judged_next = judged_reg;
        ov_next     = ov_reg;
        oy_next     = oy_reg;
        orm_next    = orm_reg;
        ost_next    = ost_reg;
        qa_we       = 1'b0;
        qa_waddr    = head_reg + Q_AW'(fill_reg);
        qa_raddr    = head_reg + Q_AW'(i_reg);
        pr_we       = 1'b0;
        pr_raddr    = wr_reg - P_AW'(1) - P_AW'(i_reg);
        dreq.start    = 1'b0;
        dreq.divisor  = den;
        // floor of a negative quotient from an unsigned divide
        dreq.dividend = numer[DIV_NB-1] ?
                        DIV_NB'(-numer + DIV_NB'(den) - DIV_NB'(1)) : numer;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        // scan results, in the cycle after the read address
        if (rv_reg)
        begin
            sum_next = sum_reg
                     + ((tag_reg >= 9'd1 && tag_reg <= w) ? SUM_BITS'(amag) : '0)
                     + ((tag_reg < pcnt) ? SUM_BITS'(pmag) : '0);
            if (tag_reg == '0)
            begin
                curr_next = araw;
                hp0_next  = ahp;
                alc_next  = (pfill_reg != '0) ? praw : araw;
            end
            if (tag_reg == w + 1'b1)
            begin
                arc_next = araw;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample_in;
                    st_next    = 1'b0;
                    state_next = ST_HPD;
                end
            end
            ST_HPD:
            begin
                d_next     = 27'(hlo_reg) + 27'(x_reg) - 27'(hli_reg);
                state_next = ST_HPC;
            end
            ST_HPC:
            begin
                hli_next   = x_reg;
                hlo_next   = hp_sat;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                qa_we     = (fill_reg < FILL_BITS'(QCAP));
                fill_next = fill_push;
                sum_next  = '0;
                i_next    = '0;
                if (fill_push > need)
                begin
                    judged_next = 1'b1;
                    state_next  = ST_SCAN;
                end
                else
                begin
                    judged_next = 1'b0;
                    y_next      = x_reg;
                    rm_next     = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                rv_next  = 1'b1;
                tag_next = i_reg;
                i_next   = i_reg + 1'b1;
                if (i_reg == w + 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EVAL0;
            end
            ST_EVAL0:
            begin
                cnt_next  = cnt_c;
                avgf_next = (sum_reg > {SUM_BITS'(cnt_c)} << 3) ? sum_reg
                          : (SUM_BITS'(cnt_c) << 3);
                hdm_next  = hd[26] ? 27'(-hd) : 27'(hd);
                cm_next   = curr_reg[SAMPLE_BITS-1] ? (~curr_reg + 1'b1) : curr_reg;
                hok_next  = hp0m > HP_BITS'(hpth_reg);
                state_next = ST_EVAL1;
            end
            ST_EVAL1:
            begin
                pa_next  = 34'(cm_reg) * 34'(cnt_reg);
                pb_next  = 45'(papr_reg) * 45'(avgf_reg);
                sa_next  = 37'(hdm_reg) * 37'(cnt_reg);
                sb_next  = 43'(sum_reg) * 43'(slew_reg);
                se_next  = 25'(cnt_reg) * 25'(EPS_SLEW_256);
                state_next = ST_EVAL2;
            end
            ST_EVAL2:
            begin
                if (start)
                begin
                    rep_next  = 1'b1;
                    step_next = '0;
                    al_next   = alc_reg;
                    ar_next   = arc_reg;
                    st_next   = 1'b1;
                end
                if (start || rep_reg)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    y_next     = curr_reg;
                    rm_next    = '0;
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                prod_next  = 36'(adiff * $signed({1'b0, k}));
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                neg_next   = numer[DIV_NB-1];
                dreq.start = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (d_done)
                begin
                    y_next     = sat_s(40'(al_reg) + 40'(off));
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                rm_next   = sat_s(40'(curr_reg) - 40'(y_reg));
                step_next = step_inc;
                if (step_inc >= w)
                    rep_next = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next  = 1'b1;
                    oy_next  = y_reg;
                    orm_next = rm_reg;
                    ost_next = st_reg;
                    if (judged_reg)
                    begin
                        lhd_next  = hp0_reg;
                        pr_we     = 1'b1;
                        wr_next   = wr_reg + 1'b1;
                        if (pfill_reg < W_BITS'(MAX_WINDOW))
                            pfill_next = pfill_reg + 1'b1;
                        head_next = head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hli_reg   <= '0;
            hlo_reg   <= '0;
            lhd_reg   <= '0;
            fill_reg  <= '0;
            head_reg  <= '0;
            wr_reg    <= '0;
            pfill_reg <= '0;
            rep_reg   <= 1'b0;
            step_reg  <= '0;
            al_reg    <= '0;
            ar_reg    <= '0;
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hli_reg   <= hli_next;
            hlo_reg   <= hlo_next;
            lhd_reg   <= lhd_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            wr_reg    <= wr_next;
            pfill_reg <= pfill_next;
            rep_reg   <= rep_next;
            step_reg  <= step_next;
            al_reg    <= al_next;
            ar_reg    <= ar_next;
            rv_reg    <= rv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        d_reg      <= d_next;
        i_reg      <= i_next;
        tag_reg    <= tag_next;
        sum_reg    <= sum_next;
        curr_reg   <= curr_next;
        hp0_reg    <= hp0_next;
        alc_reg    <= alc_next;
        arc_reg    <= arc_next;
        cnt_reg    <= cnt_next;
        avgf_reg   <= avgf_next;
        hdm_reg    <= hdm_next;
        cm_reg     <= cm_next;
        hok_reg    <= hok_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        se_reg     <= se_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        y_reg      <= y_next;
        rm_reg     <= rm_next;
        st_reg     <= st_next;
        judged_reg <= judged_next;
        oy_reg     <= oy_next;
        orm_reg    <= orm_next;
        ost_reg    <= ost_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = ov_reg;
    assign sample_out    = oy_reg;
    assign removed_out   = orm_reg;
    assign click_started = ost_reg;

endmodule
`default_nettype wire

// ===== hdl/acdr_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// acdr_assert
// Port-level checks of the click repair block, bound to the top level.
// ---------------------------------------------------------------------------
module acdr_assert
    import acdr_pkg::*;
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] sample_out,
    input wire logic signed [SAMPLE_BITS-1:0] removed_out,
    input wire logic                          click_started
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
            && $stable(removed_out) && $stable(click_started))
        else $error("stalled output beat changed");

    // an accepted beat keeps the input side busy for the high-pass steps
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input accepted during high-pass steps");

    // no result straight out of reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid at reset release");

    // a result never shows up in the cycle after an accept
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind audio_click_detect_repair acdr_assert u_acdr_assert (.*);
`default_nettype wire

// ===== bench/acdr_checker.sv =====
// ---------------------------------------------------------------------------
// acdr_checker
// Watches the sample and result channels of the click detect and repair
// block, runs its own model of the sidechain, lookahead queue and ramp
// repair on every accepted input beat, and compares every result beat.
// ---------------------------------------------------------------------------
module acdr_checker
    import acdr_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_out,
    input  wire logic signed [SAMPLE_BITS-1:0] removed_out,
    input  wire logic                          click_started,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [CFG_BITS-1:0]           cfg_data,
    output int                                 errors,
    output int                                 pending
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] y;
        logic signed [SAMPLE_BITS-1:0] rem;
        logic                          started;
    } repaired_t;

    localparam longint SMAXV = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SMINV = -SMAXV - 1;
    localparam longint HMAXV = (64'sd1 <<< (SAMPLE_BITS + 1)) - 1;
    localparam longint HMINV = -HMAXV - 1;
    localparam longint EPS_AVG = ((64'sd1 <<< (SAMPLE_BITS - 1)) + 500000) / 1000000;
    localparam longint EPS_SLW = ((64'sd1 <<< (SAMPLE_BITS - 1)) + 50000) / 100000;
    localparam int     EXP_DEPTH = 16;

    // expected results, a small ring with running write and read counts
    repaired_t exp_mem[EXP_DEPTH];
    int        exp_wr, exp_rd;

    logic [15:0] alpha;
    logic [11:0] papr_th;
    logic [22:0] hp_th;
    logic [9:0]  slew_k;
    logic [8:0]  win_reg;
    logic [10:0] dly_reg;

    longint hp_in_prev, hp_out_prev, hp_judged_prev;
    longint q_raw[QCAP];
    longint q_hp[QCAP];
    int     q_head, q_fill;
    longint hist[MAX_WINDOW];
    int     hist_wr, hist_fill;
    bit     ramp_on;
    int     ramp_k;
    longint left_anchor, right_anchor;

    function automatic longint fdiv(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    task automatic predict_repair(input longint x);
        longint hp, dlt, curr, hp0, total, cnt, floor_avg, slew_lim, off, yv, rv;
        int w, dl, need, ri, n;
        bit p_ok, h_ok, s_ok, st;
        repaired_t r;
        dlt = hp_out_prev + x - hp_in_prev;
        hp = clip(fdiv(longint'(alpha) * dlt + 32768, 65536), HMINV, HMAXV);
        hp_in_prev = x;
        hp_out_prev = hp;
        w = win_reg < 4 ? 4 : int'(win_reg);
        if (w > MAX_WINDOW) w = MAX_WINDOW;
        dl = dly_reg < 6 ? 6 : int'(dly_reg);
        if (dl > MAX_LOOKAHEAD) dl = MAX_LOOKAHEAD;
        need = dl > 2 * w + 2 ? dl : 2 * w + 2;
        if (q_fill < QCAP)
        begin
            q_raw[(q_head + q_fill) % QCAP] = x;
            q_hp[(q_head + q_fill) % QCAP] = hp;
            q_fill++;
        end
        yv = x;
        rv = 0;
        st = 0;
        if (q_fill > need)
        begin
            curr = q_raw[q_head];
            hp0 = q_hp[q_head];
            total = 0;
            cnt = 0;
            for (n = 1; n <= w; n++)
            begin
                if (hist_fill >= n)
                begin
                    total += absl(hist[(hist_wr + MAX_WINDOW - n) % MAX_WINDOW]);
                    cnt++;
                end
                if (n < q_fill)
                begin
                    total += absl(q_raw[(q_head + n) % QCAP]);
                    cnt++;
                end
            end
            floor_avg = total > EPS_AVG * cnt ? total : EPS_AVG * cnt;
            p_ok = absl(curr) * 256 * cnt > longint'(papr_th) * floor_avg;
            h_ok = absl(hp0) > longint'(hp_th);
            slew_lim = total * longint'(slew_k);
            if (slew_lim < EPS_SLW * 256 * cnt)
                slew_lim = EPS_SLW * 256 * cnt;
            s_ok = absl(hp0 - hp_judged_prev) * 256 * cnt > slew_lim;
            if (p_ok && h_ok && s_ok && !ramp_on)
            begin
                ramp_on = 1;
                ramp_k = 0;
                left_anchor = hist_fill > 0 ?
                    hist[(hist_wr + MAX_WINDOW - 1) % MAX_WINDOW] : curr;
                ri = (q_fill - 1) < (w + 1) ? (q_fill - 1) : (w + 1);
                right_anchor = q_raw[(q_head + ri) % QCAP];
                st = 1;
            end
            if (ramp_on)
            begin
                off = fdiv(2 * (right_anchor - left_anchor) * (ramp_k + 1) + w + 1,
                           2 * (longint'(w) + 1));
                yv = clip(left_anchor + off, SMINV, SMAXV);
                rv = clip(curr - yv, SMINV, SMAXV);
                ramp_k = (ramp_k + 1) & 9'h1FF;
                if (ramp_k >= w)
                    ramp_on = 0;
            end
            else
            begin
                yv = curr;
                rv = 0;
            end
            hp_judged_prev = hp0;
            hist[hist_wr] = curr;
            hist_wr = (hist_wr + 1) % MAX_WINDOW;
            if (hist_fill < MAX_WINDOW)
                hist_fill++;
            q_head = (q_head + 1) % QCAP;
            q_fill--;
        end
        r.y = yv[SAMPLE_BITS-1:0];
        r.rem = rv[SAMPLE_BITS-1:0];
        r.started = st;
        if (exp_wr - exp_rd >= EXP_DEPTH)
            report_mismatch("too many results outstanding");
        else
        begin
            exp_mem[exp_wr % EXP_DEPTH] = r;
            exp_wr++;
        end
    endtask

    assign pending = exp_wr - exp_rd;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha <= 16'd32014; papr_th <= 12'd614; hp_th <= 23'd57880;
            slew_k <= 10'd343; win_reg <= 9'd96; dly_reg <= 11'd480;
            hp_in_prev = 0; hp_out_prev = 0; hp_judged_prev = 0;
            q_head = 0; q_fill = 0; hist_wr = 0; hist_fill = 0;
            ramp_on = 0; ramp_k = 0; left_anchor = 0; right_anchor = 0;
            errors = 0;
            exp_wr = 0;
            exp_rd = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (exp_wr == exp_rd)
                    report_mismatch("result beat with nothing expected");
                else
                begin
                    repaired_t e;
                    e = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (sample_out !== e.y)
                        report_mismatch($sformatf("sample_out %0d, want %0d",
                                        sample_out, e.y));
                    if (removed_out !== e.rem)
                        report_mismatch($sformatf("removed_out %0d, want %0d",
                                        removed_out, e.rem));
                    if (click_started !== e.started)
                        report_mismatch($sformatf("click_started %0b, want %0b",
                                        click_started, e.started));
                end
            end
            if (in_valid && in_ready)
                predict_repair(longint'(sample_in));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HP_ALPHA: alpha   <= cfg_data[15:0];
                    REG_PAPR_TH:  papr_th <= cfg_data[11:0];
                    REG_HP_TH:    hp_th   <= cfg_data[22:0];
                    REG_SLEW:     slew_k  <= cfg_data[9:0];
                    REG_WINDOW:   win_reg <= cfg_data[8:0];
                    REG_DELAY:    dly_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Drives audio into the click detect and repair block in phases with
// different register settings, directed clicks and random material, with
// idling on both channels, and gives the verdict from the checker.
// ---------------------------------------------------------------------------
module tb_top
    import acdr_pkg::*;
();

    logic                          clk = 0;
    logic                          rst_n = 0;
    logic                          in_valid = 0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample_in = '0;
    logic                          out_valid;
    logic                          out_ready = 0;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic signed [SAMPLE_BITS-1:0] removed_out;
    logic                          click_started;
    logic                          cfg_we = 0;
    logic [2:0]                    cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_data = '0;
    int                            errors;
    int                            pending;

    int  send_idle_pct = 19;
    int  recv_idle_pct = 51;
    bit  hold_off = 0;
    longint cycles = 0;

    localparam longint CYCLE_LIMIT = 4000000;

    audio_click_detect_repair dut (.*);

    acdr_checker chk (.*);

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off while asked
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // valid stays up after the beat; idle gaps and wait_drained drop it
    task automatic send_beat(input int s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        sample_in <= SAMPLE_BITS'(s);
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // write enable stays up; set_all drops it after the last register
    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= CFG_BITS'(val);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    // mostly quiet noise, some loud and full-scale samples, and sparse large spikes, which the detector should catch
    task automatic send_audio(input int n, input int spike_pct);
        int i;
        int v;
        for (i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: v = int'($urandom) >>> 8;
                1: v = $urandom_range(1) ? 8388607 : -8388608;
                default: v = int'($urandom_range(4000)) - 2000;
            endcase
            if ($urandom_range(99) < spike_pct)
                v = $urandom_range(1) ? 8000000 + $urandom_range(388607)
                                      : -8000000 - $urandom_range(388608);
            send_beat(v);
        end
    endtask

    task automatic set_all(input int a, input int p, input int h,
                           input int s, input int w, input int d);
        write_reg(REG_HP_ALPHA, a);
        write_reg(REG_PAPR_TH, p);
        write_reg(REG_HP_TH, h);
        write_reg(REG_SLEW, s);
        write_reg(REG_WINDOW, w);
        write_reg(REG_DELAY, d);
        cfg_we <= 0;
    endtask

    initial
    begin
        int k;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: short window and delay, extremes, lone clicks
        write_reg(3'd7, 12345);
        set_all(32014, 614, 57880, 343, 4, 6);
        send_beat(0);
        send_beat(8388607);
        send_beat(-8388608);
        for (k = 0; k < 6; k++)
            send_beat(k);
        send_beat(8388607);
        for (k = 0; k < 6; k++)
            send_beat(-k);
        send_beat(-8388608);
        send_beat(24'sh555555);
        send_beat(-24'sh2AAAAB);
        for (k = 0; k < 6; k++)
            send_beat(100);
        wait_drained();

        // out of range window and delay, extreme thresholds
        set_all(65535, 0, 0, 0, 0, 0);
        send_audio(60, 10);
        wait_drained();
        set_all(0, 4095, 8388607, 1023, 511, 2047);
        send_audio(120, 5);
        wait_drained();

        // random phase with the default alpha, lower thresholds and a small window
        set_all(32014, 300, 20000, 100, 8, 10);
        send_audio(500, 3);
        wait_drained();

        send_idle_pct = 51;
        recv_idle_pct = 19;
        set_all($urandom_range(65535), $urandom_range(600), $urandom_range(60000),
                $urandom_range(400), $urandom_range(4, 20), $urandom_range(6, 40));
        send_audio(500, 4);
        // long receiver hold-off while the sender keeps offering
        hold_off = 1;
        fork
            send_audio(40, 4);
            begin
                repeat (3000) @(posedge clk);
                hold_off = 0;
            end
        join
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_all(50000, 200, 1000, 50, 256, 1024);
        send_audio(700, 3);
        wait_drained();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== audio_click_detect_repair.f =====
hdl/acdr_pkg.sv
hdl/acdr_ram.sv
hdl/acdr_div.sv
hdl/audio_click_detect_repair.sv
hdl/acdr_checker.sv
bench/acdr_checker.sv
bench/tb_top.sv
